### design/cts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_pkg
// Shared types, fixed-point constants and helpers of the Cook-Torrance
// shading core.
// ----------------------------------------------------------------------------
package cts_pkg;

    localparam int QB                = 30;
    localparam int VEC_FRAC_BITS_DEF = 14;
    localparam int MUL_LAT           = 3;
    localparam int DIV_STEPS         = 32 + QB;
    localparam int DIV_LAT           = DIV_STEPS + 2;
    localparam int DOT_LAT           = 2;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 48;

    typedef logic [63:0] q_t;

    localparam q_t ONE      = 64'd1 << QB;
    localparam q_t CAP      = (64'd1 << 62) - 64'd1;
    localparam q_t PI_Q     = 64'd3373259426;
    localparam q_t INV_PI_Q = 64'd341782638;
    localparam q_t EPS_Q    = 64'd10737;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_F0        = 3'd0,
        CFG_ALBEDO    = 3'd1,
        CFG_LIGHT     = 3'd2,
        CFG_INTENSITY = 3'd3,
        CFG_METALLIC  = 3'd4,
        CFG_ROUGHNESS = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic signed [15:0] view_x;
        logic signed [15:0] view_y;
        logic signed [15:0] view_z;
        logic signed [15:0] light_dir_x;
        logic signed [15:0] light_dir_y;
        logic signed [15:0] light_dir_z;
        logic signed [15:0] half_x;
        logic signed [15:0] half_y;
        logic signed [15:0] half_z;
    } shade_in_t;

    typedef struct packed {
        logic [31:0] radiance_r;
        logic [31:0] radiance_g;
        logic [31:0] radiance_b;
    } shade_out_t;

    function automatic q_t sat_add(input q_t a, input q_t b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, CAP}) ? CAP : s[63:0];
    endfunction

    function automatic q_t chan_q(input logic [47:0] pk, input int c);
        logic [15:0] w;
        w = pk[16*(2-c) +: 16];
        return q_t'(w) << 15;
    endfunction

endpackage

### design/cts_delay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_delay
// Fixed-depth register line that keeps operands level with the pipeline.
// ----------------------------------------------------------------------------
module cts_delay #(
    parameter int W     = 64,
    parameter int DEPTH = 1
) (
    input  logic         clk,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    generate
        if (DEPTH == 0)
        begin : g_thru
            assign q = d;
        end
        else
        begin : g_pipe
            logic [W-1:0] pipe_reg [DEPTH];

            always_ff @(posedge clk)
            begin
                pipe_reg[0] <= d;
                for (int i = 1; i < DEPTH; i++)
                begin
                    pipe_reg[i] <= pipe_reg[i-1];
                end
            end

            assign q = pipe_reg[DEPTH-1];
        end
    endgenerate

endmodule

### design/cts_qmul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_qmul
// Pipelined Q30 multiplier: four 32x32 partial products, truncation by 30
// bits and saturation.
// ----------------------------------------------------------------------------
module cts_qmul (
    input  logic        clk,
    input  cts_pkg::q_t a,
    input  cts_pkg::q_t b,
    output cts_pkg::q_t p
);
    import cts_pkg::*;

    q_t a_reg, b_reg;
    q_t ll_reg, lh_reg, hl_reg, hh_reg;
    q_t p_reg, p_next;
    logic [127:0] prod;

    always_comb
    begin
        prod = {hh_reg, 64'd0} + {32'd0, lh_reg, 32'd0} + {32'd0, hl_reg, 32'd0}
             + {64'd0, ll_reg};
        if (|prod[127:94])
            p_next = CAP;
        else if (prod[93:30] > CAP)
            p_next = CAP;
        else
            p_next = prod[93:30];
    end

    always_ff @(posedge clk)
    begin
        a_reg  <= a;
        b_reg  <= b;
        ll_reg <= {32'd0, a_reg[31:0]}  * {32'd0, b_reg[31:0]};
        lh_reg <= {32'd0, a_reg[31:0]}  * {32'd0, b_reg[63:32]};
        hl_reg <= {32'd0, a_reg[63:32]} * {32'd0, b_reg[31:0]};
        hh_reg <= {32'd0, a_reg[63:32]} * {32'd0, b_reg[63:32]};
        p_reg  <= p_next;
    end

    assign p = p_reg;

endmodule

### design/cts_qdiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_qdiv
// Pipelined restoring divider giving floor(n * 2^30 / d), saturated;
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module cts_qdiv (
    input  logic        clk,
    input  cts_pkg::q_t n,
    input  cts_pkg::q_t d,
    output cts_pkg::q_t q
);
    import cts_pkg::*;

    q_t                   n_reg, d_reg;
    q_t                   rem_reg [DIV_STEPS+1];
    q_t                   dsr_reg [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] dvd_reg [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] quo_reg [DIV_STEPS+1];
    logic                 sat_reg [DIV_STEPS+1];

    always_ff @(posedge clk)
    begin
        n_reg      <= n;
        d_reg      <= d;
        rem_reg[0] <= {32'd0, n_reg[63:32]};
        dvd_reg[0] <= {n_reg[31:0], {QB{1'b0}}};
        quo_reg[0] <= '0;
        dsr_reg[0] <= d_reg;
        sat_reg[0] <= ({32'd0, n_reg} >= {d_reg, 32'd0});
    end

    genvar s;
    generate
        for (s = 0; s < DIV_STEPS; s++)
        begin : g_step
            logic [64:0] trial;
            logic        ge;

            assign trial = {rem_reg[s], dvd_reg[s][DIV_STEPS-1]};
            assign ge    = (trial >= {1'b0, dsr_reg[s]});

            always_ff @(posedge clk)
            begin
                rem_reg[s+1] <= ge ? 64'(trial - {1'b0, dsr_reg[s]}) : trial[63:0];
                dvd_reg[s+1] <= {dvd_reg[s][DIV_STEPS-2:0], 1'b0};
                quo_reg[s+1] <= {quo_reg[s][DIV_STEPS-2:0], ge};
                dsr_reg[s+1] <= dsr_reg[s];
                sat_reg[s+1] <= sat_reg[s];
            end
        end
    endgenerate

    assign q = sat_reg[DIV_STEPS] ? CAP : q_t'(quo_reg[DIV_STEPS]);

endmodule

### design/cts_dot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_dot
// Four clamped dot products (N.H, N.V, N.L, H.V) scaled to Q30.
// ----------------------------------------------------------------------------
module cts_dot #(
    parameter int FRAC = cts_pkg::VEC_FRAC_BITS_DEF
) (
    input  logic              clk,
    input  cts_pkg::shade_in_t sample,
    output cts_pkg::q_t       ndh,
    output cts_pkg::q_t       ndv,
    output cts_pkg::q_t       ndl,
    output cts_pkg::q_t       hdv
);
    import cts_pkg::*;

    localparam int F2  = 2 * FRAC;
    localparam int SHL = (F2 <= QB) ? (QB - F2) : 0;
    localparam int SHR = (F2 > QB) ? (F2 - QB) : 0;

    logic signed [31:0] prod_reg [12];
    q_t                 dot_reg  [4];

    function automatic q_t to_q(input logic signed [33:0] sum);
        q_t u;
        u = {30'd0, sum};
        if (sum <= 34'sd0)
            return '0;
        return (u << SHL) >> SHR;
    endfunction

    always_ff @(posedge clk)
    begin
        prod_reg[0]  <= 32'(sample.normal_x) * 32'(sample.half_x);
        prod_reg[1]  <= 32'(sample.normal_y) * 32'(sample.half_y);
        prod_reg[2]  <= 32'(sample.normal_z) * 32'(sample.half_z);
        prod_reg[3]  <= 32'(sample.normal_x) * 32'(sample.view_x);
        prod_reg[4]  <= 32'(sample.normal_y) * 32'(sample.view_y);
        prod_reg[5]  <= 32'(sample.normal_z) * 32'(sample.view_z);
        prod_reg[6]  <= 32'(sample.normal_x) * 32'(sample.light_dir_x);
        prod_reg[7]  <= 32'(sample.normal_y) * 32'(sample.light_dir_y);
        prod_reg[8]  <= 32'(sample.normal_z) * 32'(sample.light_dir_z);
        prod_reg[9]  <= 32'(sample.half_x) * 32'(sample.view_x);
        prod_reg[10] <= 32'(sample.half_y) * 32'(sample.view_y);
        prod_reg[11] <= 32'(sample.half_z) * 32'(sample.view_z);
        for (int i = 0; i < 4; i++)
        begin
            dot_reg[i] <= to_q(34'(prod_reg[3*i]) + 34'(prod_reg[3*i+1])
                             + 34'(prod_reg[3*i+2]));
        end
    end

    assign ndh = dot_reg[0];
    assign ndv = dot_reg[1];
    assign ndl = dot_reg[2];
    assign hdv = dot_reg[3];

endmodule

### design/cook_torrance_brdf_shade_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cook_torrance_brdf_shade_core
// GGX / Smith / Schlick specular plus Lambert diffuse, RGB radiance in Q16.16.
//
//   channel   signals                               transfer when
//   input     start, busy, sample                   start && !busy
//   result    done, radiance                        done (one cycle)
//   config    cfg_valid, cfg_ready, cfg_index,      cfg_valid && cfg_ready
//             cfg_data
//
// One sample enters every cycle while busy is low; the pipeline is mostly the
// two 64-stage dividers in series (GGX term, then the specular quotient).
// Reset clears the valid line and the f0, albedo, light and metallic registers
// and loads defaults into intensity and roughness; busy is high only while in
// reset and the cycle after it. Results cannot be held off downstream.
// ----------------------------------------------------------------------------
module cook_torrance_brdf_shade_core #(
    parameter int VEC_FRAC_BITS = cts_pkg::VEC_FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  cts_pkg::shade_in_t               sample,
    output logic                             done,
    output cts_pkg::shade_out_t              radiance,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cts_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cts_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import cts_pkg::*;

    localparam int M       = MUL_LAT;
    localparam int DV      = DIV_LAT;
    localparam int DT      = DOT_LAT;
    localparam int TA2     = 2 * M;
    localparam int TK      = M;
    localparam int TN2     = DT + M;
    localparam int TB0     = (TN2 > TA2) ? TN2 : TA2;
    localparam int TT      = TB0 + M;
    localparam int TBB     = TT + M;
    localparam int TDEN    = TBB + M;
    localparam int TDD     = TDEN + DV;
    localparam int TS0     = (DT > TK) ? DT : TK;
    localparam int TS1     = TS0 + M;
    localparam int TGG     = TS1 + DV;
    localparam int TG      = TGG + M;
    localparam int TP      = DT + 3 * M;
    localparam int TSD     = DT + M;
    localparam int TF      = TP + M;
    localparam int TDF     = TF + 3 * M;
    localparam int TFD0    = (TF > TDD) ? TF : TDD;
    localparam int TFD     = TFD0 + M;
    localparam int TFG0    = (TFD > TG) ? TFD : TG;
    localparam int TFG     = TFG0 + M;
    localparam int TSPEC   = TFG + DV;
    localparam int TTR     = TSPEC + M;
    localparam int TQ      = TTR + M;
    localparam int OUT_LAT = TQ + 1;

    logic [47:0] f0_reg, albedo_reg, light_reg;
    logic [31:0] intensity_reg;
    logic [15:0] metallic_reg, roughness_reg;
    logic        busy_reg;
    logic [OUT_LAT-1:0] vld_reg;
    logic [31:0] res_reg  [3];
    logic [31:0] res_next [3];
    logic        accept;

    assign accept    = start && !busy_reg;
    assign busy      = busy_reg;
    assign cfg_ready = !busy_reg;
    assign done      = vld_reg[OUT_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b1;
            vld_reg       <= '0;
            f0_reg        <= '0;
            albedo_reg    <= '0;
            light_reg     <= '0;
            intensity_reg <= 32'd65536;
            metallic_reg  <= '0;
            roughness_reg <= 16'd16384;
        end
        else
        begin
            busy_reg <= 1'b0;
            vld_reg  <= {vld_reg[OUT_LAT-2:0], accept};
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_F0:        f0_reg        <= cfg_data;
                    CFG_ALBEDO:    albedo_reg    <= cfg_data;
                    CFG_LIGHT:     light_reg     <= cfg_data;
                    CFG_INTENSITY: intensity_reg <= cfg_data[31:0];
                    CFG_METALLIC:  metallic_reg  <= cfg_data[15:0];
                    CFG_ROUGHNESS: roughness_reg <= cfg_data[15:0];
                    default:       ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            res_reg[c] <= res_next[c];
        end
    end

    assign radiance.radiance_r = res_reg[0];
    assign radiance.radiance_g = res_reg[1];
    assign radiance.radiance_b = res_reg[2];

    // roughness terms
    q_t r30, r1, a_q, a2_q, kraw_q, k_q;
    assign r30 = q_t'(roughness_reg) << 15;
    assign r1  = r30 + ONE;
    assign k_q = kraw_q >> 3;

    cts_qmul u_a    (.clk(clk), .a(r30), .b(r30), .p(a_q));
    cts_qmul u_a2   (.clk(clk), .a(a_q), .b(a_q), .p(a2_q));
    cts_qmul u_kraw (.clk(clk), .a(r1),  .b(r1),  .p(kraw_q));

    q_t ndh, ndv, ndl, hdv;
    cts_dot #(.FRAC(VEC_FRAC_BITS)) u_dot (
        .clk(clk), .sample(sample), .ndh(ndh), .ndv(ndv), .ndl(ndl), .hdv(hdv)
    );

    // GGX distribution
    q_t ndh2_q, ndh2_b, a2_b, a2_mag, term_q, a2_t, base, bb_q, dden_q, a2_d, dd_q;

    cts_qmul u_ndh2 (.clk(clk), .a(ndh), .b(ndh), .p(ndh2_q));
    cts_delay #(.W(64), .DEPTH(TB0 - TN2)) d_ndh2 (.clk(clk), .d(ndh2_q), .q(ndh2_b));
    cts_delay #(.W(64), .DEPTH(TB0 - TA2)) d_a2b  (.clk(clk), .d(a2_q),   .q(a2_b));

    assign a2_mag = (a2_b >= ONE) ? (a2_b - ONE) : (ONE - a2_b);

    cts_qmul u_term (.clk(clk), .a(ndh2_b), .b(a2_mag), .p(term_q));
    cts_delay #(.W(64), .DEPTH(M)) d_a2t (.clk(clk), .d(a2_b), .q(a2_t));

    always_comb
    begin
        if (a2_t >= ONE)
            base = sat_add(ONE, term_q);
        else if (term_q >= ONE)
            base = term_q - ONE;
        else
            base = ONE - term_q;
    end

    cts_qmul u_bb  (.clk(clk), .a(base), .b(base), .p(bb_q));
    cts_qmul u_den (.clk(clk), .a(PI_Q), .b(bb_q), .p(dden_q));
    cts_delay #(.W(64), .DEPTH(TDEN - TT)) d_a2d (.clk(clk), .d(a2_t), .q(a2_d));
    cts_qdiv u_dd  (.clk(clk), .n(a2_d), .d(dden_q), .q(dd_q));

    // Smith geometry
    q_t ndl_s, ndv_s, k_s, k_mag, tl_q, tv_q, ndl_s1, ndv_s1, k_s1;
    q_t den_l, den_v, gl_q, gv_q, g_q;

    cts_delay #(.W(64), .DEPTH(TS0 - DT)) d_ndl_s (.clk(clk), .d(ndl), .q(ndl_s));
    cts_delay #(.W(64), .DEPTH(TS0 - DT)) d_ndv_s (.clk(clk), .d(ndv), .q(ndv_s));
    cts_delay #(.W(64), .DEPTH(TS0 - TK)) d_k_s   (.clk(clk), .d(k_q), .q(k_s));

    assign k_mag = (k_s > ONE) ? (k_s - ONE) : (ONE - k_s);

    cts_qmul u_tl (.clk(clk), .a(ndl_s), .b(k_mag), .p(tl_q));
    cts_qmul u_tv (.clk(clk), .a(ndv_s), .b(k_mag), .p(tv_q));
    cts_delay #(.W(64), .DEPTH(M)) d_ndl_s1 (.clk(clk), .d(ndl_s), .q(ndl_s1));
    cts_delay #(.W(64), .DEPTH(M)) d_ndv_s1 (.clk(clk), .d(ndv_s), .q(ndv_s1));
    cts_delay #(.W(64), .DEPTH(M)) d_k_s1   (.clk(clk), .d(k_s),   .q(k_s1));

    assign den_l = (k_s1 <= ONE) ? sat_add(tl_q, k_s1) : ((k_s1 > tl_q) ? (k_s1 - tl_q) : '0);
    assign den_v = (k_s1 <= ONE) ? sat_add(tv_q, k_s1) : ((k_s1 > tv_q) ? (k_s1 - tv_q) : '0);

    cts_qdiv u_gl (.clk(clk), .n(ndl_s1), .d(den_l), .q(gl_q));
    cts_qdiv u_gv (.clk(clk), .n(ndv_s1), .d(den_v), .q(gv_q));
    cts_qmul u_g  (.clk(clk), .a(gl_q), .b(gv_q), .p(g_q));

    // Fresnel weight and specular denominator
    q_t x_f, x2_q, x4_q, x_f4, p_q, p_f, nvl_q, sden, sden_f, dd_f, g_f, ndl_o;

    assign x_f = (hdv >= ONE) ? '0 : (ONE - hdv);

    cts_qmul u_x2 (.clk(clk), .a(x_f),  .b(x_f),  .p(x2_q));
    cts_qmul u_x4 (.clk(clk), .a(x2_q), .b(x2_q), .p(x4_q));
    cts_delay #(.W(64), .DEPTH(2 * M)) d_xf (.clk(clk), .d(x_f), .q(x_f4));
    cts_qmul u_p  (.clk(clk), .a(x4_q), .b(x_f4), .p(p_q));
    cts_delay #(.W(64), .DEPTH(TF - TP)) d_p (.clk(clk), .d(p_q), .q(p_f));

    cts_qmul u_nvl (.clk(clk), .a(ndv), .b(ndl), .p(nvl_q));
    assign sden = sat_add((nvl_q > (CAP >> 2)) ? CAP : (nvl_q << 2), EPS_Q);
    cts_delay #(.W(64), .DEPTH(TFG - TSD)) d_sden (.clk(clk), .d(sden), .q(sden_f));

    cts_delay #(.W(64), .DEPTH(TFD0 - TDD)) d_dd  (.clk(clk), .d(dd_q), .q(dd_f));
    cts_delay #(.W(64), .DEPTH(TFG0 - TG))  d_g   (.clk(clk), .d(g_q),  .q(g_f));
    cts_delay #(.W(64), .DEPTH(TTR - DT))   d_ndl (.clk(clk), .d(ndl),  .q(ndl_o));

    // material terms
    logic met_neg;
    q_t   met_sh, met_mag, inten;
    assign met_sh  = q_t'(metallic_reg) << 15;
    assign met_neg = (met_sh > ONE);
    assign met_mag = met_neg ? (met_sh - ONE) : (ONE - met_sh);
    assign inten   = q_t'(intensity_reg) << 14;

    genvar c;
    generate
        for (c = 0; c < 3; c++)
        begin : g_chan
            q_t   f0_c, alb_c, lt_c, fm_q, f, omf_mag, kd_q, ak_q, df_q, df_mag;
            q_t   f_f, fd_q, fd_f, fg_q, sp_q, rad_q, tot_u, tr_q, qq;
            logic omf_neg, kd_neg, df_neg, dfs_neg, pos, pos_t, pos_q;
            logic signed [65:0] tot;

            assign f0_c  = chan_q(f0_reg, c);
            assign alb_c = chan_q(albedo_reg, c);
            assign lt_c  = chan_q(light_reg, c);

            cts_qmul u_fm (.clk(clk), .a(f0_c), .b(ONE - p_q), .p(fm_q));
            assign f       = sat_add(fm_q, p_f);
            assign omf_neg = (f > ONE);
            assign omf_mag = omf_neg ? (f - ONE) : (ONE - f);

            cts_qmul u_kd (.clk(clk), .a(omf_mag), .b(met_mag), .p(kd_q));
            cts_delay #(.W(1), .DEPTH(M)) d_kdn
                (.clk(clk), .d(omf_neg ^ met_neg), .q(kd_neg));
            cts_qmul u_ak (.clk(clk), .a(alb_c), .b(kd_q), .p(ak_q));
            cts_qmul u_df (.clk(clk), .a(ak_q), .b(INV_PI_Q), .p(df_q));
            cts_delay #(.W(1), .DEPTH(2 * M)) d_dfn (.clk(clk), .d(kd_neg), .q(df_neg));
            cts_delay #(.W(65), .DEPTH(TSPEC - TDF)) d_dfs
                (.clk(clk), .d({df_neg, df_q}), .q({dfs_neg, df_mag}));

            cts_delay #(.W(64), .DEPTH(TFD0 - TF)) d_f (.clk(clk), .d(f), .q(f_f));
            cts_qmul u_fd (.clk(clk), .a(f_f), .b(dd_f), .p(fd_q));
            cts_delay #(.W(64), .DEPTH(TFG0 - TFD)) d_fd (.clk(clk), .d(fd_q), .q(fd_f));
            cts_qmul u_fg (.clk(clk), .a(fd_f), .b(g_f), .p(fg_q));
            cts_qdiv u_sp (.clk(clk), .n(fg_q), .d(sden_f), .q(sp_q));

            assign tot   = dfs_neg ? ($signed({2'b00, sp_q}) - $signed({2'b00, df_mag}))
                                   : ($signed({2'b00, sp_q}) + $signed({2'b00, df_mag}));
            assign pos   = (tot > 66'sd0);
            assign tot_u = tot[63:0];

            cts_qmul u_rad (.clk(clk), .a(lt_c), .b(inten), .p(rad_q));
            cts_qmul u_tr  (.clk(clk), .a(tot_u), .b(rad_q), .p(tr_q));
            cts_delay #(.W(1), .DEPTH(M)) d_pos (.clk(clk), .d(pos), .q(pos_t));
            cts_qmul u_q   (.clk(clk), .a(tr_q), .b(ndl_o), .p(qq));
            cts_delay #(.W(1), .DEPTH(M)) d_posq (.clk(clk), .d(pos_t), .q(pos_q));

            assign res_next[c] = !pos_q ? 32'd0
                               : ((|qq[63:46]) ? 32'hFFFF_FFFF : qq[45:14]);
        end
    endgenerate

`ifndef SYNTHESIS
    a_accept_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##OUT_LAT done)
        else $error("accepted sample did not complete on time");

    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, OUT_LAT))
        else $error("result strobe without matching transfer");
`endif

endmodule
